### src/alcs_pkg.sv
`timescale 1ns / 1ps

package alcs_pkg;

    // Default build parameters.
    localparam int MAX_CHAIN_DEF  = 256;
    localparam int DUMMY_LEDS_DEF = 2;

    // Line codes and word size.
    localparam logic [3:0] CODE_ZERO = 4'd7;
    localparam logic [3:0] CODE_ONE  = 4'd14;
    localparam int         WORD_BITS = 24;

    // Register reset values.
    localparam logic [7:0] NUM_LEDS_RST    = 8'd8;
    localparam logic [7:0] RESET_SLOTS_RST = 8'd2;

    // Queue between the front and the back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register map, indexed by word address.
    localparam logic [1:0] REG_NUM_LEDS    = 2'd0;
    localparam logic [1:0] REG_RESET_SLOTS = 2'd1;
    localparam logic [1:0] REG_CONTINUOUS  = 2'd2;

    typedef enum logic [1:0] {
        OP_SET_COLOR = 2'd0,
        OP_SLOT      = 2'd1,
        OP_REFRESH   = 2'd2
    } op_t;

    typedef struct packed {
        logic [7:0] number_of_leds;
        logic [7:0] reset_slots;
        logic       continuous_scan;
    } cfg_t;

    // One LED word ready for serialization.
    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 half;
    } slot_word_t;

    typedef struct packed {
        logic       valid;
        slot_word_t data;
    } push_t;

endpackage

### src/alcs_front.sv
`timescale 1ns / 1ps

module alcs_front #(
    parameter int MAX_CHAIN  = alcs_pkg::MAX_CHAIN_DEF,
    parameter int DUMMY_LEDS = alcs_pkg::DUMMY_LEDS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  operation,
    input  logic [7:0]                  led_index,
    input  logic [7:0]                  color_first,
    input  logic [7:0]                  color_second,
    input  logic [7:0]                  color_third,
    input  logic                        second_half,
    input  alcs_pkg::cfg_t              cfg,
    input  logic [alcs_pkg::QCNT_W-1:0] fifo_count,
    output alcs_pkg::push_t             push
);
    import alcs_pkg::*;

    localparam int AW = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;

    // Color store and its registered read port.
    logic [WORD_BITS-1:0] mem [MAX_CHAIN];
    logic [WORD_BITS-1:0] rdata_reg;

    // Clearing pass after reset.
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    // Scan state.
    logic [8:0] ptr_reg, ptr_next;
    logic [7:0] cd_reg, cd_next;
    logic       pend_reg, pend_next;

    // Second stage: the item whose store data is now available.
    logic                 s1_set_reg;
    logic                 s1_emit_reg;
    logic                 s1_zero_reg;
    logic                 s1_half_reg;
    logic [AW-1:0]        s1_addr_reg;
    logic [WORD_BITS-1:0] s1_color_reg;
    logic                 s1_byp_reg;
    logic [WORD_BITS-1:0] s1_bypdata_reg;

    logic                 accept;
    logic [AW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] rdata_eff;
    logic                 s1_wr;
    logic                 set_inrange;
    logic                 pend_eff;
    logic [7:0]           cd_dec;
    logic                 set_ok;
    logic                 emit;

    // Accept only when the queue can take whatever is already in flight.
    assign in_ready = !clr_busy_reg &&
                      ((int'(fifo_count) + int'(s1_emit_reg)) < QUEUE_DEPTH);
    assign accept = in_valid && in_ready;

    assign rd_addr = (op_t'(operation) == OP_SET_COLOR) ? AW'(led_index) : AW'(ptr_reg);

    // Forward a write made in the same cycle that this item's read was issued.
    assign rdata_eff = s1_byp_reg ? s1_bypdata_reg : rdata_reg;
    assign s1_wr     = s1_set_reg && (rdata_eff != s1_color_reg);
    assign pend_eff  = pend_reg | s1_wr;

    assign set_inrange = (10'(led_index) < (10'(cfg.number_of_leds) + 10'(DUMMY_LEDS))) &&
                         (int'(led_index) < MAX_CHAIN);

    assign cd_dec = (cd_reg != 8'd0) ? cd_reg - 8'd1 : 8'd0;

    // Classify the item and update the scan state.
    always_comb
    begin
        ptr_next  = ptr_reg;
        cd_next   = cd_reg;
        pend_next = pend_eff;
        set_ok    = 1'b0;
        emit      = 1'b0;
        if (accept)
        begin
            unique case (op_t'(operation))
                OP_SET_COLOR:
                begin
                    set_ok = set_inrange;
                end
                OP_SLOT:
                begin
                    if (ptr_reg > {1'b0, cfg.number_of_leds})
                    begin
                        if (cfg.continuous_scan && (cd_dec == 8'd0))
                        begin
                            cd_next  = cfg.reset_slots;
                            ptr_next = 9'd0;
                        end
                        else
                        begin
                            cd_next = cd_dec;
                        end
                    end
                    else
                    begin
                        emit     = 1'b1;
                        ptr_next = ptr_reg + 9'd1;
                    end
                end
                OP_REFRESH:
                begin
                    if (!cfg.continuous_scan && pend_eff && (cd_reg == 8'd0))
                    begin
                        ptr_next  = 9'd0;
                        pend_next = 1'b0;
                        cd_next   = cfg.reset_slots;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Hand emitting slot events to the queue.
    always_comb
    begin
        push.valid     = s1_emit_reg;
        push.data.word = s1_zero_reg ? '0 : rdata_eff;
        push.data.half = s1_half_reg;
    end

    // Store write port (clearing pass or color update) and read port.
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (s1_wr)
        begin
            mem[s1_addr_reg] <= s1_color_reg;
        end
        rdata_reg <= mem[rd_addr];
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            ptr_reg      <= 9'd0;
            cd_reg       <= RESET_SLOTS_RST;
            pend_reg     <= 1'b1;
            s1_set_reg   <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                if (clr_addr_reg == AW'(MAX_CHAIN - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
                else
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                end
            end
            ptr_reg     <= ptr_next;
            cd_reg      <= cd_next;
            pend_reg    <= pend_next;
            s1_set_reg  <= set_ok;
            s1_emit_reg <= emit;
        end
    end

    // Second stage payload.
    always_ff @(posedge clk)
    begin
        s1_addr_reg    <= rd_addr;
        s1_color_reg   <= {color_first, color_second, color_third};
        s1_half_reg    <= !second_half;
        s1_zero_reg    <= (int'(ptr_reg) >= MAX_CHAIN);
        s1_byp_reg     <= s1_wr && (s1_addr_reg == rd_addr);
        s1_bypdata_reg <= s1_color_reg;
    end

endmodule

### src/alcs_fifo.sv
`timescale 1ns / 1ps

module alcs_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  alcs_pkg::push_t             push,
    input  logic                        pop,
    output alcs_pkg::slot_word_t        head,
    output logic [alcs_pkg::QCNT_W-1:0] count,
    output logic                        nonempty
);
    import alcs_pkg::*;

    slot_word_t        q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head     = q_reg[rd_ptr_reg];
    assign count    = count_reg;
    assign nonempty = (count_reg != '0);

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            q_reg[wr_ptr_reg] <= push.data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push.valid && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push.valid)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

### src/alcs_back.sv
`timescale 1ns / 1ps

module alcs_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 nonempty,
    input  alcs_pkg::slot_word_t head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [3:0]           compare_value,
    output logic [4:0]           bit_position,
    output logic                 buffer_half,
    output logic                 last_in_run
);
    import alcs_pkg::*;

    logic                 busy_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic                 half_reg;
    logic [4:0]           cnt_reg;
    logic                 out_valid_reg;
    logic [3:0]           cv_reg;
    logic [4:0]           bp_reg;
    logic                 bh_reg;
    logic                 last_reg;

    logic advance;
    logic emit;
    logic last_bit;
    logic load;

    // One code per cycle unless stalled; a new word loads as the last code leaves.
    assign advance  = !out_valid_reg || out_ready;
    assign emit     = busy_reg && advance;
    assign last_bit = (cnt_reg == 5'(WORD_BITS - 1));
    assign load     = nonempty && (!busy_reg || (emit && last_bit));
    assign pop      = load;

    assign out_valid     = out_valid_reg;
    assign compare_value = cv_reg;
    assign bit_position  = bp_reg;
    assign buffer_half   = bh_reg;
    assign last_in_run   = last_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
            end
            else if (emit && last_bit)
            begin
                busy_reg <= 1'b0;
            end

            if (load)
            begin
                cnt_reg <= 5'd0;
            end
            else if (emit)
            begin
                cnt_reg <= cnt_reg + 5'd1;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Shift register and output payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= head.word;
            half_reg <= head.half;
        end
        else if (emit)
        begin
            word_reg <= {word_reg[WORD_BITS-2:0], 1'b0};
        end

        if (emit)
        begin
            cv_reg   <= word_reg[WORD_BITS-1] ? CODE_ONE : CODE_ZERO;
            bp_reg   <= cnt_reg;
            bh_reg   <= half_reg;
            last_reg <= last_bit;
        end
    end

endmodule

### src/addressable_led_chain_serializer_top.sv
`timescale 1ns / 1ps
// Addressable LED chain serializer.
// Input channel (in_valid/in_ready): set-color, slot-event and refresh items.
// Output channel (out_valid/out_ready): one PWM compare code per item, 24 codes
// per slot event that falls inside the chain, MSB of the first color byte first.
// Configuration goes through the APB port: LED count, gap length, scan mode.
// A slot event's word passes the front end's second stage, the word queue and the
// back-end shifter before its first code reaches the output register. Set-color
// and refresh items produce no output. The serializer emits one code per cycle
// while out_ready does not stall it; that pace is set by the bit shifter in the
// back end. A four-entry word queue sits between the classifier and the shifter.
// After reset the color store is cleared one entry per cycle, with in_ready low
// until all MAX_CHAIN entries are cleared; registers can be written then.
// When the receiver stalls, the output register holds its code, the queue fills,
// and in_ready drops only once the queue has no room for another slot event.
module addressable_led_chain_serializer_top #(
    parameter int MAX_CHAIN  = alcs_pkg::MAX_CHAIN_DEF,
    parameter int DUMMY_LEDS = alcs_pkg::DUMMY_LEDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input items
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [7:0]  led_index,
    input  logic [7:0]  color_first,
    input  logic [7:0]  color_second,
    input  logic [7:0]  color_third,
    input  logic        second_half,
    // Output items
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  compare_value,
    output logic [4:0]  bit_position,
    output logic        buffer_half,
    output logic        last_in_run
);
    import alcs_pkg::*;

    logic [7:0]        num_leds_reg;
    logic [7:0]        reset_slots_reg;
    logic              continuous_reg;
    cfg_t              cfg;
    push_t             push;
    slot_word_t        head;
    logic [QCNT_W-1:0] fifo_count;
    logic              fifo_nonempty;
    logic              pop;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_leds_reg    <= NUM_LEDS_RST;
            reset_slots_reg <= RESET_SLOTS_RST;
            continuous_reg  <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_NUM_LEDS:    num_leds_reg    <= pwdata[7:0];
                REG_RESET_SLOTS: reset_slots_reg <= pwdata[7:0];
                REG_CONTINUOUS:  continuous_reg  <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (paddr[3:2])
            REG_NUM_LEDS:    prdata = {24'd0, num_leds_reg};
            REG_RESET_SLOTS: prdata = {24'd0, reset_slots_reg};
            REG_CONTINUOUS:  prdata = {31'd0, continuous_reg};
            default:         prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        cfg.number_of_leds  = num_leds_reg;
        cfg.reset_slots     = reset_slots_reg;
        cfg.continuous_scan = continuous_reg;
    end

    alcs_front #(
        .MAX_CHAIN  (MAX_CHAIN),
        .DUMMY_LEDS (DUMMY_LEDS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .led_index    (led_index),
        .color_first  (color_first),
        .color_second (color_second),
        .color_third  (color_third),
        .second_half  (second_half),
        .cfg          (cfg),
        .fifo_count   (fifo_count),
        .push         (push)
    );

    alcs_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .pop      (pop),
        .head     (head),
        .count    (fifo_count),
        .nonempty (fifo_nonempty)
    );

    alcs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .nonempty      (fifo_nonempty),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .compare_value (compare_value),
        .bit_position  (bit_position),
        .buffer_half   (buffer_half),
        .last_in_run   (last_in_run)
    );

    // The queue never takes a word when it is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        push.valid && !pop |-> int'(fifo_count) < QUEUE_DEPTH)
    else $error("word queue overflow");

    // The back end never pops an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> fifo_nonempty)
    else $error("word queue underflow");

    // The last code of a run carries the top bit position.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_in_run |-> bit_position == 5'(WORD_BITS - 1))
    else $error("last code at wrong bit position");

    // Codes of one word follow each other without gaps.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_in_run |=>
            out_valid && (bit_position == $past(bit_position) + 5'd1))
    else $error("code run broken");

endmodule
